/* hdl/b85_pkg.sv */
// Package for the base85 stream decoder: job type, status codes, digit map
// and the tail padding multipliers. No dependencies.
package b85_pkg;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_CHAR = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    localparam int unsigned GROUP_DIGITS = 5;

    // One unit of work for the back end: a finished group, a tail or an error.
    typedef struct packed {
        logic        err;   // invalid character: one zero byte with error status
        logic        last;  // the item that closed this job carried stream_last
        logic        ovf;   // the group value already wrapped past 32 bits
        logic [1:0]  pad;   // number of padding digits (value 84) still to fold in
        logic [1:0]  nbm1;  // bytes to emit minus one
        logic [31:0] val;   // group value modulo 2^32
    } t_job;

    // Maps a byte to {valid, digit}.
    function automatic logic [7:0] b85_digit(input logic [7:0] c);
        logic [7:0] r;
        r = 8'h00;
        if (c >= "0" && c <= "9") begin
            r = {1'b1, 7'(c - 8'h30)};
        end else if (c >= "A" && c <= "Z") begin
            r = {1'b1, 7'(c - 8'h41 + 8'd10)};
        end else if (c >= "a" && c <= "z") begin
            r = {1'b1, 7'(c - 8'h61 + 8'd36)};
        end else begin
            case (c)
                8'd33:   r = {1'b1, 7'd62};
                8'd35:   r = {1'b1, 7'd63};
                8'd36:   r = {1'b1, 7'd64};
                8'd37:   r = {1'b1, 7'd65};
                8'd38:   r = {1'b1, 7'd66};
                8'd40:   r = {1'b1, 7'd67};
                8'd41:   r = {1'b1, 7'd68};
                8'd42:   r = {1'b1, 7'd69};
                8'd43:   r = {1'b1, 7'd70};
                8'd45:   r = {1'b1, 7'd71};
                8'd59:   r = {1'b1, 7'd72};
                8'd60:   r = {1'b1, 7'd73};
                8'd61:   r = {1'b1, 7'd74};
                8'd62:   r = {1'b1, 7'd75};
                8'd63:   r = {1'b1, 7'd76};
                8'd64:   r = {1'b1, 7'd77};
                8'd94:   r = {1'b1, 7'd78};
                8'd95:   r = {1'b1, 7'd79};
                8'd96:   r = {1'b1, 7'd80};
                8'd123:  r = {1'b1, 7'd81};
                8'd124:  r = {1'b1, 7'd82};
                8'd125:  r = {1'b1, 7'd83};
                8'd126:  r = {1'b1, 7'd84};
                default: r = 8'h00;
            endcase
        end
        return r;
    endfunction

    // 85 to the power of the padding digit count.
    function automatic logic [19:0] b85_pad_mult(input logic [1:0] k);
        logic [19:0] m;
        unique case (k)
            2'd0:    m = 20'd1;
            2'd1:    m = 20'd85;
            2'd2:    m = 20'd7225;
            default: m = 20'd614125;
        endcase
        return m;
    endfunction

endpackage

/* hdl/b85_front.sv */
// Front end of the base85 decoder: classifies characters, folds digits into
// the group value and posts one job per finished group, tail or error.
// Depends on b85_pkg.
module b85_front
    import b85_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_fire,
    input  logic [7:0] i_char,
    input  logic       i_last,
    output logic       o_push,
    output t_job       o_job
);

    logic [31:0] r_val, n_val;
    logic [2:0]  r_cnt, n_cnt;
    logic        r_ovf, n_ovf;
    logic        r_disc, n_disc;

    logic [7:0]  dig;
    logic [38:0] fold_full;
    logic        fold_ovf;
    logic [2:0]  cnt1;

    always_comb begin
        dig       = b85_digit(i_char);
        fold_full = {7'b0, r_val} * 39'd85 + {32'b0, dig[6:0]};
        fold_ovf  = r_ovf | (|fold_full[38:32]);
        cnt1      = r_cnt + 3'd1;

        n_val  = r_val;
        n_cnt  = r_cnt;
        n_ovf  = r_ovf;
        n_disc = r_disc;
        o_push = 1'b0;
        o_job  = '{err: 1'b0, last: i_last, ovf: fold_ovf, pad: 2'd0,
                   nbm1: 2'd3, val: fold_full[31:0]};

        if (i_fire) begin
            if (r_disc) begin
                if (i_last) begin
                    n_disc = 1'b0;
                end
            end else if (!dig[7]) begin
                n_val     = '0;
                n_cnt     = '0;
                n_ovf     = 1'b0;
                n_disc    = !i_last;
                o_push    = 1'b1;
                o_job.err = 1'b1;
                o_job.ovf = 1'b0;
                o_job.nbm1 = 2'd0;
                o_job.val = '0;
            end else if (cnt1 == 3'(GROUP_DIGITS) || i_last) begin
                // A full group, or a tail that the padding completes. A tail of
                // a single digit carries no byte and is simply dropped.
                n_val      = '0;
                n_cnt      = '0;
                n_ovf      = 1'b0;
                o_push     = (cnt1 >= 3'd2);
                o_job.pad  = 2'(3'(GROUP_DIGITS) - cnt1);
                o_job.nbm1 = 2'(cnt1 - 3'd2);
            end else begin
                n_val = fold_full[31:0];
                n_cnt = cnt1;
                n_ovf = fold_ovf;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_val  <= '0;
            r_cnt  <= '0;
            r_ovf  <= 1'b0;
            r_disc <= 1'b0;
        end else begin
            r_val  <= n_val;
            r_cnt  <= n_cnt;
            r_ovf  <= n_ovf;
            r_disc <= n_disc;
        end
    end

endmodule

/* hdl/b85_fifo.sv */
// Short job queue between the front and back ends of the base85 decoder.
// Depends on b85_pkg.
module b85_fifo
    import b85_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    output logic o_valid,
    input  logic i_pop,
    output t_job o_job
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_count;
    logic          do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

/* hdl/b85_back.sv */
// Back end of the base85 decoder: applies tail padding to a job and sends
// its bytes out one transaction at a time, most significant first.
// Depends on b85_pkg.
module b85_back
    import b85_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_job_valid,
    input  t_job       i_job,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_byte,
    output logic       o_run_end,
    output logic       o_stream_end,
    output logic [1:0] o_status
);

    logic [31:0] r_val;
    logic [1:0]  r_left;
    logic        r_last;
    logic [1:0]  r_st;
    logic        r_valid;

    logic [19:0] mult;
    logic [51:0] padded;
    logic        pad_ovf;
    logic        done;

    // Padding k digits of 84 equals value * 85^k + (85^k - 1).
    always_comb begin
        mult    = b85_pad_mult(i_job.pad);
        padded  = 52'(i_job.val) * 52'(mult) + 52'(mult - 20'd1);
        pad_ovf = i_job.ovf | (|padded[51:32]);
    end

    assign done  = i_ready && (r_left == 2'd0);
    assign o_pop = i_job_valid && (!r_valid || done);

    assign o_valid      = r_valid;
    assign o_byte       = r_val[31:24];
    assign o_run_end    = (r_left == 2'd0);
    assign o_stream_end = r_last && (r_left == 2'd0);
    assign o_status     = r_st;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_val  <= padded[31:0];
            r_left <= i_job.nbm1;
            r_last <= i_job.last;
            r_st   <= i_job.err ? ST_BAD_CHAR : (pad_ovf ? ST_OVERFLOW : ST_OK);
        end else if (r_valid && i_ready) begin
            r_val  <= {r_val[23:0], 8'h00};
            r_left <= r_left - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (done) begin
            r_valid <= 1'b0;
        end
    end

endmodule

/* hdl/base85_stream_decoder.sv */
// Base85 (RFC 1924 alphabet) stream decoder, one character per transaction.
// The first byte of a group passes the job queue and then the byte shifter before it
// is offered. Throughput: one character per cycle while the queue has room; the output
// side sends one byte per cycle while the receiver is ready, up to four per group.
// Reset: synchronous, active low; clears the group, the discard flag and the queue.
module base85_stream_decoder
    import b85_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
    input  logic        s_axis_tlast,   // stream_last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] data_byte
    output logic [2:0]  m_axis_tuser,   // [0] run_end, [2:1] status
    output logic        m_axis_tlast    // stream_end
);

    logic fire;
    logic push, full, job_valid, pop;
    t_job front_job, head_job;
    logic run_end;
    logic [1:0] status;

    assign s_axis_tready = !full;
    assign fire          = s_axis_tvalid && s_axis_tready;

    b85_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_char  (s_axis_tdata),
        .i_last  (s_axis_tlast),
        .o_push  (push),
        .o_job   (front_job)
    );

    b85_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .o_full  (full),
        .o_valid (job_valid),
        .i_pop   (pop),
        .o_job   (head_job)
    );

    b85_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job_valid  (job_valid),
        .i_job        (head_job),
        .o_pop        (pop),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_byte       (m_axis_tdata),
        .o_run_end    (run_end),
        .o_stream_end (m_axis_tlast),
        .o_status     (status)
    );

    assign m_axis_tuser = {status, run_end};

endmodule

/* hdl/b85_checker.sv */
// Port-level checks for the base85 stream decoder, bound to the top level.
// Depends on b85_pkg.
module b85_checker
    import b85_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic [2:0] m_axis_tuser,
    input logic       m_axis_tlast
);

    // A stalled result holds its contents.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("stalled result changed");

    // The end of a stream is always the end of the item's run.
    a_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[0])
        else $error("stream end without run end");

    // An error transaction is a single zero byte.
    a_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[2:1] == ST_BAD_CHAR
        |-> m_axis_tdata == 8'h00 && m_axis_tuser[0])
        else $error("malformed error result");

    // Overflow status stays on every byte of a group.
    a_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tuser[0]
        && m_axis_tuser[2:1] == ST_OVERFLOW
        |=> m_axis_tvalid && m_axis_tuser[2:1] == ST_OVERFLOW)
        else $error("overflow status changed within a group");

    // Reset empties the output.
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("result offered right after reset");

endmodule

bind base85_stream_decoder b85_checker u_b85_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

/* tb/sv/tb_base85_stream_decoder.sv */
// Self-checking testbench for base85_stream_decoder: directed and random character streams
// with a built-in decoder model and a scoreboard of expected bytes.
// Depends on b85_pkg for the status codes and on the decoder RTL.
`timescale 1ns / 100ps

module tb_base85_stream_decoder
    import b85_pkg::*;
();

    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       run_end;
        logic       stream_end;
        logic [1:0] status;
    } t_decoded_byte;

    // Punctuation digits 62..84 in alphabet order.
    localparam logic [7:0] PUNCT [0:22] = '{
        8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h28, 8'h29, 8'h2A, 8'h2B, 8'h2D, 8'h3B, 8'h3C,
        8'h3D, 8'h3E, 8'h3F, 8'h40, 8'h5E, 8'h5F, 8'h60, 8'h7B, 8'h7C, 8'h7D, 8'h7E
    };

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;   // [7:0] char_code
    logic       s_axis_tlast = 1'b0;    // stream_last
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;           // [7:0] data_byte
    logic [2:0] m_axis_tuser;           // [0] run_end, [2:1] status
    logic       m_axis_tlast;           // stream_end

    // Decoder model state.
    logic [31:0] model_value = '0;
    int          model_digits = 0;
    logic        model_wrapped = 1'b0;
    logic        model_discarding = 1'b0;

    t_decoded_byte expected_bytes[$];
    int            error_count = 0;
    int            sent_chars = 0;
    int            cycle_count = 0;
    int            send_idle_pct = 0;
    int            recv_stall_pct = 0;

    base85_stream_decoder i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic logic [7:0] char_of_digit(int d);
        if (d < 10) begin
            return 8'(8'h30 + d);
        end else if (d < 36) begin
            return 8'(8'h41 + d - 10);
        end else if (d < 62) begin
            return 8'(8'h61 + d - 36);
        end
        return PUNCT[d - 62];
    endfunction

    function automatic int digit_value(logic [7:0] c);
        for (int d = 0; d < 85; d++) begin
            if (char_of_digit(d) == c) begin
                return d;
            end
        end
        return -1;
    endfunction

    function automatic void fold_digit(int d);
        logic [63:0] t;
        t = {32'd0, model_value} * 64'd85 + 64'(d);
        if (t[63:32] != 0) begin
            model_wrapped = 1'b1;
        end
        model_value = t[31:0];
        model_digits++;
    endfunction

    function automatic void clear_group();
        model_value = '0;
        model_digits = 0;
        model_wrapped = 1'b0;
    endfunction

    // Works out the bytes that one accepted character produces.
    function automatic void decode_char(logic [7:0] c, logic is_last);
        int            d;
        int            n_bytes;
        t_decoded_byte r;
        if (model_discarding) begin
            if (is_last) begin
                model_discarding = 1'b0;
            end
            return;
        end
        d = digit_value(c);
        if (d < 0) begin
            clear_group();
            model_discarding = !is_last;
            r = '{data_byte: 8'h00, run_end: 1'b1, stream_end: is_last, status: ST_BAD_CHAR};
            expected_bytes.push_back(r);
            return;
        end
        fold_digit(d);
        if (model_digits >= 5) begin
            n_bytes = 4;
        end else if (is_last) begin
            n_bytes = model_digits - 1;
            while (model_digits < 5) begin
                fold_digit(84);
            end
        end else begin
            return;
        end
        for (int k = 0; k < n_bytes; k++) begin
            r.data_byte = 8'(model_value >> (24 - 8 * k));
            r.run_end = (k == n_bytes - 1);
            r.stream_end = is_last && (k == n_bytes - 1);
            r.status = model_wrapped ? ST_OVERFLOW : ST_OK;
            expected_bytes.push_back(r);
        end
        clear_group();
    endfunction

    function automatic void check_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
        if (act_v !== exp_v) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
            error_count++;
        end
    endfunction

    // Output monitor and random back-pressure.
    always @(posedge i_clk) begin
        t_decoded_byte e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_bytes.size() == 0) begin
                $display("%0t: unexpected byte, expected none, actual %0h user %0h last %0b",
                         $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
                error_count++;
            end else begin
                e = expected_bytes.pop_front();
                check_field("data_byte", e.data_byte, m_axis_tdata);
                check_field("run_end", 8'(e.run_end), 8'(m_axis_tuser[0]));
                check_field("stream_end", 8'(e.stream_end), 8'(m_axis_tlast));
                check_field("status", 8'(e.status), 8'(m_axis_tuser[2:1]));
            end
        end
        m_axis_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_char(logic [7:0] c, logic is_last);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= c;
        s_axis_tlast <= is_last;
        do @(posedge i_clk); while (!s_axis_tready);
        sent_chars++;
        decode_char(c, is_last);
    endtask

    task automatic send_text(string s, logic last_at_end);
        for (int i = 0; i < s.len(); i++) begin
            send_char(s[i], last_at_end && (i == s.len() - 1));
        end
    endtask

    // Holds the input until every expected byte has left the block.
    task automatic wait_for_drain();
        s_axis_tvalid <= 1'b0;
        while (expected_bytes.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic test_full_groups();
        send_text("00000", 1'b0);
        // Stream end on the fifth digit: the group wraps past 32 bits.
        send_text("~~~~~", 1'b1);
        wait_for_drain();
    endtask

    task automatic test_tails();
        send_text("0", 1'b1);
        send_text("~~", 1'b1);
        send_text("9Zz", 1'b1);
        send_text("!#|}", 1'b1);
        wait_for_drain();
    endtask

    task automatic test_bad_chars();
        send_char(8'h00, 1'b1);
        // A bad character drops the partial group, then the rest of the stream is ignored.
        send_text("ab", 1'b0);
        send_char(8'hFF, 1'b0);
        send_text("AB", 1'b1);
        wait_for_drain();
    endtask

    function automatic logic [7:0] random_bad_char();
        logic [7:0] c;
        do c = 8'($urandom_range(255)); while (digit_value(c) >= 0);
        return c;
    endfunction

    task automatic send_random_stream();
        int         pick;
        int         len;
        int         bad_at;
        bit         high_digits;
        logic [7:0] c;
        pick = $urandom_range(99);
        if (pick < 8) begin
            send_char(8'($urandom_range(255)), 1'($urandom_range(1)));
        end else begin
            len = $urandom_range(1, 14);
            bad_at = (pick < 20) ? $urandom_range(0, len - 1) : -1;
            high_digits = ($urandom_range(3) == 0);
            for (int i = 0; i < len; i++) begin
                if (i == bad_at) begin
                    c = random_bad_char();
                end else if (high_digits) begin
                    c = char_of_digit($urandom_range(78, 84));
                end else begin
                    c = char_of_digit($urandom_range(0, 84));
                end
                send_char(c, i == len - 1);
            end
        end
    endtask

    task automatic test_random_streams(int n_chars, int idle_pct, int stall_pct);
        int start;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        start = sent_chars;
        while (sent_chars - start < n_chars) begin
            send_random_stream();
        end
        wait_for_drain();
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_full_groups();
        test_tails();
        test_bad_chars();
        test_random_streams(110, 0, 0);
        test_random_streams(110, 88, 0);
        test_random_streams(110, 0, 88);
        test_random_streams(100, 36, 36);
        repeat (20) @(posedge i_clk);
        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

/* sim.f */
hdl/b85_pkg.sv
hdl/b85_front.sv
hdl/b85_fifo.sv
hdl/b85_back.sv
hdl/base85_stream_decoder.sv
hdl/b85_checker.sv
tb/sv/tb_base85_stream_decoder.sv
